[hw/rtl/slip_receive_deframer_macros.svh]
// Assertion helpers shared by the deframer modules.
`ifndef SLIP_RECEIVE_DEFRAMER_MACROS_SVH
`define SLIP_RECEIVE_DEFRAMER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Cause in one cycle, consequence in the next, checked outside reset.
`define SLD_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

[hw/rtl/sld_pkg.sv]
package sld_pkg;

    localparam int MAX_LEN   = 2048;
    localparam int FILL_W    = 12;
    localparam int OFF_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] SL_END     = 8'hC0;
    localparam logic [7:0] SL_ESC     = 8'hDB;
    localparam logic [7:0] SL_TEND    = 8'hDC;
    localparam logic [7:0] SL_TESC    = 8'hDD;
    localparam logic [7:0] ABORT_CHAR = 8'h1B;

    localparam logic [3:0] NIB_IP   = 4'h4;
    localparam logic [3:0] NIB_UTCP = 4'h7;

    localparam logic [32:0] ABORT_IDLE = 33'd1;
    localparam logic [32:0] ABORT_WIN  = 33'd8;
    localparam logic [1:0]  ABORT_CNT  = 2'd3;
    localparam logic [FILL_W-1:0] MIN_FRAME = FILL_W'(3);
    localparam logic [FILL_W-1:0] AUTO_MIN  = FILL_W'(40);

    typedef enum logic [2:0] {
        KIND_DATA   = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_ERROR  = 3'd2,
        KIND_IGNORE = 3'd3,
        KIND_ABORT  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PT_IP    = 2'd0,
        PT_CTCP  = 2'd1,
        PT_UTCP  = 2'd2,
        PT_OTHER = 2'd3
    } t_ptype;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBUG_ABORT = 2'd0,
        CFG_COMPRESS    = 2'd1,
        CFG_AUTOCOMP    = 2'd2,
        CFG_IF_UP       = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic debug_abort_enable;
        logic compress_enable;
        logic autocomp_enable;
        logic interface_up;
    } t_cfg;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data_byte;
        logic [OFF_W-1:0]  byte_offset;
        logic [FILL_W-1:0] frame_length;
        t_ptype            packet_type;
    } t_result;

endpackage

[hw/rtl/sld_decode.sv]
`include "slip_receive_deframer_macros.svh"

module sld_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_line_fault,
    input  logic [31:0]                  i_now_seconds,
    input  sld_pkg::t_cfg                i_cfg,
    output logic                         o_res_valid,
    output sld_pkg::t_result             o_res
);

    logic [sld_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                       r_esc, n_esc;
    logic                       r_err, n_err;
    logic [7:0]                 r_first, n_first;
    logic [1:0]                 r_cnt, n_cnt;
    logic [31:0]                r_start, n_start;
    logic [31:0]                r_last, n_last;
    logic                       r_learned, n_learned;

    logic [1:0]        cnt;
    logic              abort;
    logic [7:0]        c;
    logic              store;
    logic              close;
    logic              good;
    sld_pkg::t_ptype   ptype;

    always_comb begin
        n_fill      = r_fill;
        n_esc       = r_esc;
        n_err       = r_err;
        n_first     = r_first;
        n_cnt       = r_cnt;
        n_start     = r_start;
        n_last      = r_last;
        n_learned   = r_learned;
        o_res_valid = 1'b0;
        o_res       = '0;
        cnt         = r_cnt;
        abort       = 1'b0;
        c           = i_rx_byte;
        store       = 1'b0;
        close       = 1'b0;
        good        = 1'b0;

        if (r_fill == '0) begin
            ptype = sld_pkg::PT_OTHER;
        end else if (r_first[7:4] == sld_pkg::NIB_IP) begin
            ptype = sld_pkg::PT_IP;
        end else if (r_first[7]) begin
            ptype = sld_pkg::PT_CTCP;
        end else if (r_first[7:4] == sld_pkg::NIB_UTCP) begin
            ptype = sld_pkg::PT_UTCP;
        end else begin
            ptype = sld_pkg::PT_OTHER;
        end

        if (i_line_fault) begin
            n_err = 1'b1;
        end else begin
            if (i_cfg.debug_abort_enable) begin
                if (i_rx_byte == sld_pkg::ABORT_CHAR) begin
                    // Window and idle sums are taken one bit wider so they never wrap.
                    if (cnt != 2'd0 &&
                        {1'b0, i_now_seconds} >= {1'b0, r_start} + sld_pkg::ABORT_WIN) begin
                        cnt = 2'd0;
                    end
                    if ({1'b0, i_now_seconds} >= {1'b0, r_last} + sld_pkg::ABORT_IDLE) begin
                        cnt = cnt + 2'd1;
                        if (cnt == 2'd1) begin
                            n_start = i_now_seconds;
                        end
                        if (cnt == sld_pkg::ABORT_CNT) begin
                            cnt   = 2'd0;
                            abort = 1'b1;
                        end
                    end
                    n_cnt = cnt;
                end else begin
                    n_cnt = 2'd0;
                end
                // The aborting byte leaves the idle reference where it was.
                if (!abort) n_last = i_now_seconds;
            end

            if (abort) begin
                n_err             = 1'b0;
                n_fill            = '0;
                n_esc             = 1'b0;
                o_res_valid       = 1'b1;
                o_res.kind        = sld_pkg::KIND_ABORT;
            end else begin
                case (i_rx_byte)
                    sld_pkg::SL_TESC: begin
                        if (r_esc) c = sld_pkg::SL_ESC;
                        store = 1'b1;
                    end
                    sld_pkg::SL_TEND: begin
                        if (r_esc) c = sld_pkg::SL_END;
                        store = 1'b1;
                    end
                    sld_pkg::SL_ESC: begin
                        n_esc = 1'b1;
                    end
                    sld_pkg::SL_END: begin
                        close = 1'b1;
                    end
                    default: begin
                        store = 1'b1;
                    end
                endcase

                if (close) begin
                    o_res_valid        = 1'b1;
                    o_res.frame_length = r_fill;
                    o_res.packet_type  = ptype;
                    n_fill             = '0;
                    n_esc              = 1'b0;
                    if (r_err) begin
                        n_err      = 1'b0;
                        o_res.kind = sld_pkg::KIND_IGNORE;
                    end else if (r_fill < sld_pkg::MIN_FRAME) begin
                        o_res.kind = sld_pkg::KIND_IGNORE;
                    end else begin
                        if (ptype == sld_pkg::PT_IP) begin
                            good = 1'b1;
                        end else if (i_cfg.compress_enable || r_learned) begin
                            good = (ptype != sld_pkg::PT_OTHER);
                        end else if (i_cfg.autocomp_enable && ptype == sld_pkg::PT_UTCP &&
                                     r_fill >= sld_pkg::AUTO_MIN) begin
                            good      = 1'b1;
                            n_learned = 1'b1;
                        end
                        if (!good) begin
                            o_res.kind = sld_pkg::KIND_ERROR;
                        end else if (!i_cfg.interface_up) begin
                            o_res.kind = sld_pkg::KIND_IGNORE;
                        end else begin
                            o_res.kind = sld_pkg::KIND_ACCEPT;
                        end
                    end
                end else if (store) begin
                    o_res_valid = 1'b1;
                    n_esc       = 1'b0;
                    if (r_fill < sld_pkg::FILL_W'(sld_pkg::MAX_LEN)) begin
                        if (r_fill == '0) n_first = c;
                        n_fill            = r_fill + sld_pkg::FILL_W'(1);
                        o_res.kind        = sld_pkg::KIND_DATA;
                        o_res.data_byte   = c;
                        o_res.byte_offset = r_fill[sld_pkg::OFF_W-1:0];
                    end else begin
                        // Overflow: drop what is stored and flag the frame so that its end is ignored.
                        n_err              = 1'b1;
                        n_fill             = '0;
                        o_res.kind         = sld_pkg::KIND_ERROR;
                        o_res.frame_length = sld_pkg::FILL_W'(sld_pkg::MAX_LEN);
                        o_res.packet_type  = sld_pkg::PT_OTHER;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_esc     <= 1'b0;
            r_err     <= 1'b0;
            r_first   <= '0;
            r_cnt     <= '0;
            r_start   <= '0;
            r_last    <= '0;
            r_learned <= 1'b0;
        end else if (i_en) begin
            r_fill    <= n_fill;
            r_esc     <= n_esc;
            r_err     <= n_err;
            r_first   <= n_first;
            r_cnt     <= n_cnt;
            r_start   <= n_start;
            r_last    <= n_last;
            r_learned <= n_learned;
        end
    end

    `SLD_ASSERT(a_fill_bound, r_fill <= sld_pkg::FILL_W'(sld_pkg::MAX_LEN), "fill count beyond buffer size")
    `SLD_ASSERT(a_abort_cnt, r_cnt != sld_pkg::ABORT_CNT, "abort count reached limit without abort")
    `SLD_ASSERT_NEXT(a_close_empties, i_en && o_res_valid && o_res.kind != sld_pkg::KIND_DATA, r_fill == '0 && !r_esc, "frame not restarted after frame result")

endmodule

[hw/rtl/sld_out_reg.sv]
module sld_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sld_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output sld_pkg::t_result o_res
);

    logic             r_valid;
    sld_pkg::t_result r_res;

    // The slot can take a new result when empty or when it is drained this cycle.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[hw/rtl/slip_receive_deframer.sv]
// SLIP receive deframer: takes one serial byte per cycle on the input channel and gives at
// most one result per byte (a decoded data byte, a frame verdict or a debug abort) on the
// output channel. A sustained rate of one byte per clock is kept as long as results are taken;
// each accepted byte is held in the input register, and the single decode pass writes its result
// into the output register, where it is presented; while that register has no room the byte waits.
// Escape bytes and fault bytes produce no result. Configuration writes take effect on the next
// edge and are to be made only while no byte is in flight.
`include "slip_receive_deframer_macros.svh"

module slip_receive_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_line_fault,
    input  logic [31:0]                         i_now_seconds,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_kind,
    output logic [7:0]                          o_data_byte,
    output logic [sld_pkg::OFF_W-1:0]           o_byte_offset,
    output logic [sld_pkg::FILL_W-1:0]          o_frame_length,
    output logic [1:0]                          o_packet_type,
    input  logic                                i_cfg_wr_en,
    input  logic [sld_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic                                i_cfg_data
);

    sld_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_fault;
    logic [31:0]      r_now;

    logic             proc;
    logic             out_free;
    logic             res_valid;
    sld_pkg::t_result res;
    sld_pkg::t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debug_abort_enable <= 1'b0;
            r_cfg.compress_enable    <= 1'b0;
            r_cfg.autocomp_enable    <= 1'b1;
            r_cfg.interface_up       <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (sld_pkg::t_cfg_idx'(i_cfg_index))
                sld_pkg::CFG_DEBUG_ABORT: r_cfg.debug_abort_enable <= i_cfg_data;
                sld_pkg::CFG_COMPRESS:    r_cfg.compress_enable    <= i_cfg_data;
                sld_pkg::CFG_AUTOCOMP:    r_cfg.autocomp_enable    <= i_cfg_data;
                sld_pkg::CFG_IF_UP:       r_cfg.interface_up       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held byte is decoded once the output register has room for its result.
    assign proc       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte  <= i_rx_byte;
            r_fault <= i_line_fault;
            r_now   <= i_now_seconds;
        end
    end

    sld_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (proc),
        .i_rx_byte     (r_byte),
        .i_line_fault  (r_fault),
        .i_now_seconds (r_now),
        .i_cfg         (r_cfg),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sld_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (proc && res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_byte_offset  = out_res.byte_offset;
    assign o_frame_length = out_res.frame_length;
    assign o_packet_type  = out_res.packet_type;

    `SLD_ASSERT_NEXT(a_in_hold, r_in_valid && !proc, r_in_valid && $stable(r_byte) && $stable(r_now), "held byte lost before decode")
    `SLD_ASSERT_NEXT(a_out_load, proc && res_valid, o_out_valid, "decoded result not presented")
    `SLD_ASSERT(a_no_clobber, !(proc && res_valid && o_out_valid && !i_out_ready), "pending result overwritten")

endmodule
